@@ rtl/core/rdc_pkg.sv @@
package rdc_pkg;

  // default sizes
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned MAX_DIGITS_DEF  = 32;

  // fixed field widths
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DIGIT_W = 4;

  // radix range
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  // dividend bits retired per divider cycle
  localparam int unsigned STEP_BITS = 4;

  // divider status seen by the sequencer
  typedef struct packed {
    logic done;
    logic quot_zero;
  } div_status_t;

endpackage

@@ rtl/core/rdc_divider.sv @@
module rdc_divider #(
  parameter int unsigned VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [VALUE_WIDTH-1:0]            dividend,
  input  logic [rdc_pkg::RADIX_W-1:0]       divisor,
  output rdc_pkg::div_status_t              status,
  output logic [VALUE_WIDTH-1:0]            quotient,
  output logic [rdc_pkg::DIGIT_W-1:0]       remainder
);

  localparam int unsigned STEP  = rdc_pkg::STEP_BITS;
  localparam int unsigned PAD_W = ((VALUE_WIDTH + STEP - 1) / STEP) * STEP;
  localparam int unsigned NSTEP = PAD_W / STEP;
  localparam int unsigned CNT_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int unsigned DW    = rdc_pkg::DIGIT_W;

  logic [PAD_W-1:0] work;
  logic [PAD_W-1:0] work_next;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    rem_next;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             done;
  logic [STEP-1:0]  qbits;

  // restoring division, STEP bits per cycle, remainder stays below the radix
  always_comb begin
    logic [DW:0]   t;
    logic [DW-1:0] r;
    r = rem;
    qbits = '0;
    for (int i = 0; i < STEP; i++) begin
      t = {r, work[PAD_W-1-i]};
      if (t >= divisor) begin
        qbits[STEP-1-i] = 1'b1;
        r = DW'(t - divisor);
      end else begin
        r = t[DW-1:0];
      end
    end
    rem_next  = r;
    work_next = {work[PAD_W-STEP-1:0], qbits};
  end

  // load, iterate, flag done
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NSTEP - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      work <= PAD_W'(dividend);
      rem  <= '0;
    end else if (run) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient         = work[VALUE_WIDTH-1:0];
  assign remainder        = rem;
  assign status.done      = done;
  assign status.quot_zero = (work == '0);

endmodule

@@ rtl/core/rdc_digit_ram.sv @@
module rdc_digit_ram #(
  parameter int unsigned DEPTH = rdc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [rdc_pkg::DIGIT_W-1:0]  wdata,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [rdc_pkg::DIGIT_W-1:0]  rdata
);

  logic [rdc_pkg::DIGIT_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/radix_digit_converter_top.sv @@
// Converts an unsigned value into its digits in a radix from 2 to 16 (a radix
// below 2 acts as 2, above 16 as 16) and sends them most significant first,
// one word per digit, with last set on the final digit; zero gives one digit 0.
// A value needing more than MAX_DIGITS digits sends only its MAX_DIGITS most
// significant ones. Drive start while busy is low to hand in a word; busy
// stays high until the last digit is issued. Each digit is shown for exactly
// one cycle with strobe, and the receiver cannot hold it off. The shared
// divider retires 4 dividend bits per cycle and yields one digit per
// division, and the first strobe follows the divide phase, after a
// registered read of the digit memory.
module radix_digit_converter_top #(
  parameter int unsigned VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [VALUE_WIDTH-1:0]       value,
  input  logic [rdc_pkg::RADIX_W-1:0]  radix,
  output logic                         busy,
  output logic                         strobe,
  output logic [rdc_pkg::DIGIT_W-1:0]  digit,
  output logic                         last
);

  localparam int unsigned ADDR_W = $clog2(VALUE_WIDTH);
  localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned REM_W  = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                        state;
  logic [rdc_pkg::RADIX_W-1:0]   radix_q;
  logic [rdc_pkg::RADIX_W-1:0]   radix_clamp;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_inc;
  logic [REM_W-1:0]              remaining;
  logic [REM_W-1:0]              remaining_next;
  logic [ADDR_W-1:0]             rd_addr;

  logic                          div_start;
  logic [VALUE_WIDTH-1:0]        div_dividend;
  logic [rdc_pkg::RADIX_W-1:0]   div_divisor;
  rdc_pkg::div_status_t          div_status;
  logic [VALUE_WIDTH-1:0]        div_quot;
  logic [rdc_pkg::DIGIT_W-1:0]   div_rem;
  logic                          ram_we;

  // clamp the radix into range
  always_comb begin
    priority if (radix < rdc_pkg::RADIX_MIN) begin
      radix_clamp = rdc_pkg::RADIX_MIN;
    end else if (radix > rdc_pkg::RADIX_MAX) begin
      radix_clamp = rdc_pkg::RADIX_MAX;
    end else begin
      radix_clamp = radix;
    end
  end

  // launch the divider on a new word or on a nonzero quotient
  assign div_start    = ((state == ST_IDLE) && start) ||
                        ((state == ST_DIV) && div_status.done && !div_status.quot_zero);
  assign div_dividend = (state == ST_IDLE) ? value : div_quot;
  assign div_divisor  = (state == ST_IDLE) ? radix_clamp : radix_q;
  assign ram_we       = (state == ST_DIV) && div_status.done;

  // digit count after this remainder, and how many of them go out
  always_comb begin
    count_inc = count + CNT_W'(1);
    if (int'(count_inc) > int'(MAX_DIGITS)) begin
      remaining_next = REM_W'(MAX_DIGITS);
    end else begin
      remaining_next = REM_W'(count_inc);
    end
  end

  rdc_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .status    (div_status),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  rdc_digit_ram #(
    .DEPTH (VALUE_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (div_rem),
    .raddr (rd_addr),
    .rdata (digit)
  );

  // sequencer: divide out digits least significant first, then read back reversed
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      strobe    <= 1'b0;
      last      <= 1'b0;
      count     <= '0;
      remaining <= '0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            radix_q <= radix_clamp;
            count   <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_status.done) begin
            count <= count_inc;
            if (div_status.quot_zero) begin
              rd_addr   <= count[ADDR_W-1:0];
              remaining <= remaining_next;
              state     <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          strobe    <= 1'b1;
          last      <= (remaining == REM_W'(1));
          rd_addr   <= rd_addr - ADDR_W'(1);
          remaining <= remaining - REM_W'(1);
          if (remaining == REM_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

  // a digit only follows a read cycle
  a_strobe_after_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == ST_EMIT)
    else $error("strobe without a read cycle");

  // the divider only finishes while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> state == ST_DIV)
    else $error("divider done outside divide phase");

  // last marks a delivered digit
  a_last_with_strobe: assert property (@(posedge clk) disable iff (rst)
    last |-> strobe)
    else $error("last without strobe");

  // an accepted word makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

endmodule
